@@ rtl/core/bitmap_slot_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// bitmap slot allocator assertion macros
// immediate-style wrappers around concurrent checks on clk / rst_n
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BSA_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_slot_allocator check failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_slot_allocator check failed");

`else

`define BSA_ASSERT_IMPLIES(lbl, ante, cons)
`define BSA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/bsa_pkg.sv @@
// ----------------------------------------------------------------------------
// bsa_pkg
// shared widths, codes and types of the bitmap slot allocator
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int OP_W       = 2;
    localparam int SLOT_W     = 11;
    localparam int OFFSET_W   = 26;
    localparam int STATUS_W   = 2;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // bitmap word handled by the shared word unit
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;
    localparam int LIM_W   = BIT_W + 1;
    // words covering the largest slot count the register can hold
    localparam int NWORD_W = SLOT_W - BIT_W + 1;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LENGTH = 1'd1;

    localparam logic [SLOT_W-1:0] SLOT_COUNT_RESET  = 11'd1024;
    localparam logic [LEN_W-1:0]  SLOT_LENGTH_RESET = 16'd16;

    typedef struct packed {
        logic             search;   // 1: find lowest free bit, 0: clear one bit
        logic [BIT_W-1:0] bit_sel;
        logic [LIM_W-1:0] lim;      // number of live bits in this word
    } word_ctl_t;

    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  pos;
        logic              bit_used;
        logic [WORD_W-1:0] wr_data;
    } word_res_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [OFFSET_W-1:0] byte_offset;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   free_count;
        logic                became_full;
        logic                first_release;
        logic                all_free;
    } result_t;

endpackage

@@ rtl/core/bsa_req_if.sv @@
// ----------------------------------------------------------------------------
// bsa_req_if
// request channel: operation and slot index with valid / ready
// ----------------------------------------------------------------------------
interface bsa_req_if;

    logic                       valid;
    logic                       ready;
    logic [bsa_pkg::OP_W-1:0]   operation;
    logic [bsa_pkg::SLOT_W-1:0] slot_index;

    modport source (output valid, output operation, output slot_index, input ready);
    modport sink   (input valid, input operation, input slot_index, output ready);

endinterface

@@ rtl/core/bsa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// bsa_rsp_if
// response channel: grant, offset, status and count flags with valid / ready
// ----------------------------------------------------------------------------
interface bsa_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [bsa_pkg::SLOT_W-1:0]   slot;
    logic [bsa_pkg::OFFSET_W-1:0] byte_offset;
    logic [bsa_pkg::STATUS_W-1:0] status;
    logic [bsa_pkg::SLOT_W-1:0]   free_count;
    logic                         became_full;
    logic                         first_release;
    logic                         all_free;

    modport source (
        output valid, output slot, output byte_offset, output status,
        output free_count, output became_full, output first_release,
        output all_free, input ready
    );
    modport sink (
        input valid, input slot, input byte_offset, input status,
        input free_count, input became_full, input first_release,
        input all_free, output ready
    );

endinterface

@@ rtl/core/bsa_ram.sv @@
// ----------------------------------------------------------------------------
// bsa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bsa_word_unit.sv @@
// ----------------------------------------------------------------------------
// bsa_word_unit
// shared bitmap word unit: finds the lowest free live bit and sets it, or
// tests one bit and clears it
// ----------------------------------------------------------------------------
module bsa_word_unit (
    input  logic [bsa_pkg::WORD_W-1:0] rd_data,
    input  bsa_pkg::word_ctl_t         ctl,
    output bsa_pkg::word_res_t         res
);

    import bsa_pkg::*;

    logic [WORD_W-1:0] live_mask;
    logic [WORD_W-1:0] busy;
    logic [BIT_W-1:0]  first_free;
    logic [BIT_W-1:0]  tgt;
    logic [WORD_W-1:0] tgt_hot;

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            live_mask[b] = LIM_W'(b) < ctl.lim;
        end
        // bits past the slot count look used
        busy = rd_data | ~live_mask;

        first_free = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!busy[b])
            begin
                first_free = BIT_W'(b);
            end
        end

        tgt     = ctl.search ? first_free : ctl.bit_sel;
        tgt_hot = WORD_W'(1) << tgt;

        res.found    = ~&busy;
        res.pos      = first_free;
        res.bit_used = rd_data[ctl.bit_sel];
        res.wr_data  = ctl.search ? (rd_data | tgt_hot) : (rd_data & ~tgt_hot);
    end

endmodule

@@ rtl/core/bitmap_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// usage-bitmap allocator of equal-sized slots with free count and flags
// ----------------------------------------------------------------------------
// usage: req carries operation (allocate, free, initialise) and a 1-based
// slot_index; rsp returns one beat per request with the slot, its byte
// offset, status, free count and the full / first-release / all-free flags.
// slot_count and slot_length are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while no request is in flight,
// the block itself does not enforce this. the bitmap sits in a ram of
// 32-bit words; one word unit checks a word per cycle. allocate scans
// the live words in order until it finds a free bit; free reads, tests
// and clears one bit; initialise rewrites every word. one request is
// worked at a time. after reset a clearing pass writes zero to all
// ceil(MAX_SLOTS/32) words before req.ready rises.
// rsp is a registered stage: a request may be taken while the previous
// beat waits; if rsp is stalled the finished result is held back and
// req stays low until the stage empties.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_macros.svh"

module bitmap_slot_allocator #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data,
    bsa_req_if.sink                        req,
    bsa_rsp_if.source                      rsp
);

    import bsa_pkg::*;

    localparam int DEPTH   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW      = $clog2(DEPTH + 1);
    localparam int FW      = $clog2(MAX_SLOTS + 1);
    localparam int RST_CNT = (int'(SLOT_COUNT_RESET) > MAX_SLOTS) ?
                             MAX_SLOTS : int'(SLOT_COUNT_RESET);
    localparam int PROD_W  = LEN_W + SLOT_W;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_MUL     = 3'd3;
    localparam logic [2:0] S_FREE_EV = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]        state_reg,     state_next;
    logic [PW-1:0]     ptr_reg,       ptr_next;
    logic              ev_valid_reg,  ev_valid_next;
    logic [PW-1:0]     ev_ptr_reg,    ev_ptr_next;
    logic [FW-1:0]     free_reg,      free_next;
    logic              init_pend_reg, init_pend_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [SLOT_W-1:0] slot_count_reg;
    logic [LEN_W-1:0]  slot_length_reg;

    result_t           res_reg,       res_next;
    result_t           rsp_data_reg,  rsp_data_next;
    logic [SLOT_W-1:0] grant_reg,     grant_next;
    logic [SLOT_W-1:0] idx_reg,       idx_next;
    logic [AW-1:0]     faddr_reg,     faddr_next;
    logic [BIT_W-1:0]  fbit_reg,      fbit_next;

    logic [SLOT_W-1:0]  cnt;
    logic [NWORD_W-1:0] nwords;
    logic [SLOT_W-1:0]  idx_m1;
    logic               accept;
    logic               last_word;
    logic [PROD_W-1:0]  prod;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    word_ctl_t wctl;
    word_res_t wres;

    bsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bsa_word_unit u_word (
        .rd_data (ram_rdata),
        .ctl     (wctl),
        .res     (wres)
    );

    // live slot count, limited to the bitmap size
    assign cnt       = (32'(slot_count_reg) > MAX_SLOTS) ? SLOT_W'(MAX_SLOTS) : slot_count_reg;
    assign nwords    = NWORD_W'((32'(cnt) + WORD_W - 1) >> BIT_W);
    assign idx_m1    = req.slot_index - SLOT_W'(1);
    assign accept    = req.valid && req.ready;
    assign last_word = (32'(ev_ptr_reg) + 32'd1) == 32'(nwords);
    assign prod      = PROD_W'(slot_length_reg) * PROD_W'(grant_reg);

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        wctl.search  = (state_reg == S_SCAN);
        wctl.bit_sel = fbit_reg;
        if (last_word && (cnt[BIT_W-1:0] != '0))
        begin
            wctl.lim = LIM_W'(cnt[BIT_W-1:0]);
        end
        else
        begin
            wctl.lim = LIM_W'(WORD_W);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        ev_valid_next  = 1'b0;
        ev_ptr_next    = ev_ptr_reg;
        free_next      = free_reg;
        init_pend_next = init_pend_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        res_next       = res_reg;
        rsp_data_next  = rsp_data_reg;
        grant_next     = grant_reg;
        idx_next       = idx_reg;
        faddr_next     = faddr_reg;
        fbit_next      = fbit_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[AW-1:0];
        ram_wdata      = '0;
        ram_raddr      = ptr_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                ram_we = 1'b1;
                if (ptr_reg == PW'(DEPTH - 1))
                begin
                    ptr_next = '0;
                    if (init_pend_reg)
                    begin
                        init_pend_next = 1'b0;
                        free_next      = FW'(cnt);
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            S_IDLE:
            begin
                // free reads its word straight away
                ram_raddr = AW'(idx_m1 >> BIT_W);
                if (accept)
                begin
                    res_next        = '0;
                    res_next.status = ST_OK;
                    ptr_next        = '0;
                    case (req.operation)
                        OP_ALLOC:
                        begin
                            if (cnt == '0)
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            if ((req.slot_index == '0) || (req.slot_index > cnt))
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                idx_next   = req.slot_index;
                                faddr_next = AW'(idx_m1 >> BIT_W);
                                fbit_next  = idx_m1[BIT_W-1:0];
                                state_next = S_FREE_EV;
                            end
                        end
                        OP_INIT:
                        begin
                            init_pend_next = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        default:
                        begin
                            res_next.status = ST_BAD;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // reads run one word ahead of the word unit
                if (32'(ptr_reg) < 32'(nwords))
                begin
                    ev_valid_next = 1'b1;
                    ev_ptr_next   = ptr_reg;
                    ptr_next      = ptr_reg + PW'(1);
                end
                if (ev_valid_reg)
                begin
                    if (wres.found)
                    begin
                        ram_we        = 1'b1;
                        ram_waddr     = ev_ptr_reg[AW-1:0];
                        ram_wdata     = wres.wr_data;
                        grant_next    = SLOT_W'({ev_ptr_reg, wres.pos});
                        ev_valid_next = 1'b0;
                        if (free_reg != '0)
                        begin
                            res_next.became_full = (free_reg == FW'(1));
                            free_next            = free_reg - FW'(1);
                        end
                        state_next = S_MUL;
                    end
                    else if (last_word)
                    begin
                        ev_valid_next   = 1'b0;
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                end
            end

            S_MUL:
            begin
                res_next.slot        = grant_reg + SLOT_W'(1);
                res_next.byte_offset = prod[OFFSET_W-1:0];
                state_next           = S_DONE;
            end

            S_FREE_EV:
            begin
                if (wres.bit_used)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = faddr_reg;
                    ram_wdata              = wres.wr_data;
                    res_next.slot          = idx_reg;
                    res_next.first_release = (free_reg == '0);
                    if (32'(free_reg) < MAX_SLOTS)
                    begin
                        free_next = free_reg + FW'(1);
                    end
                end
                else
                begin
                    res_next.status = ST_BAD;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next           = 1'b1;
                    rsp_data_next            = res_reg;
                    rsp_data_next.free_count = SLOT_W'(free_reg);
                    rsp_data_next.all_free   = (32'(free_reg) == 32'(cnt));
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            free_reg      <= FW'(RST_CNT);
            init_pend_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            ev_valid_reg  <= ev_valid_next;
            free_reg      <= free_next;
            init_pend_reg <= init_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg  <= SLOT_COUNT_RESET;
            slot_length_reg <= SLOT_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLOT_COUNT:  slot_count_reg  <= cfg_data[SLOT_W-1:0];
                REG_SLOT_LENGTH: slot_length_reg <= cfg_data[LEN_W-1:0];
                default:         slot_length_reg <= slot_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        rsp_data_reg <= rsp_data_next;
        grant_reg    <= grant_next;
        idx_reg      <= idx_next;
        faddr_reg    <= faddr_next;
        fbit_reg     <= fbit_next;
        ev_ptr_reg   <= ev_ptr_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.slot          = rsp_data_reg.slot;
    assign rsp.byte_offset   = rsp_data_reg.byte_offset;
    assign rsp.status        = rsp_data_reg.status;
    assign rsp.free_count    = rsp_data_reg.free_count;
    assign rsp.became_full   = rsp_data_reg.became_full;
    assign rsp.first_release = rsp_data_reg.first_release;
    assign rsp.all_free      = rsp_data_reg.all_free;

    `BSA_ASSERT_IMPLIES(a_free_bound, 1'b1, 32'(free_reg) <= MAX_SLOTS)
    `BSA_ASSERT_IMPLIES(a_err_no_grant, rsp.valid && (rsp.status != ST_OK), (rsp.slot == '0) && (rsp.byte_offset == '0))
    `BSA_ASSERT_IMPLIES(a_full_is_empty, rsp.valid && rsp.became_full, rsp.free_count == '0)
    `BSA_ASSERT_IMPLIES(a_scan_in_range, ev_valid_reg, 32'(ev_ptr_reg) < 32'(nwords))
    `BSA_ASSERT_NEXT(a_busy_after_accept, accept, !req.ready)

endmodule
